// ===== rtl/core/vbc_pkg.sv =====
// ----------------------------------------------------------------------------
// vbc_pkg
// Shared types, codes and helpers of the Verlet ball collision step block.
// ----------------------------------------------------------------------------
package vbc_pkg;

	localparam int MAX_BALLS_DEF = 64;
	localparam int IDX_W         = 6;
	localparam int POS_W         = 24;

	// input commands
	localparam logic [1:0] CMD_TICK  = 2'd0;
	localparam logic [1:0] CMD_SPAWN = 2'd1;
	localparam logic [1:0] CMD_NUDGE = 2'd2;

	// result status codes
	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_FULL    = 2'd1;
	localparam logic [1:0] STAT_NO_BALL = 2'd2;

	// configuration register indexes
	localparam logic [1:0] CFG_WIDTH   = 2'd0;
	localparam logic [1:0] CFG_HEIGHT  = 2'd1;
	localparam logic [1:0] CFG_GRAVITY = 2'd2;

	localparam logic [11:0] WIDTH_RST   = 12'd400;
	localparam logic [11:0] HEIGHT_RST  = 12'd400;
	localparam logic [7:0]  GRAVITY_RST = 8'd26;

	// geometry in Q16.8
	localparam int RADIUS_Q   = 2560;
	localparam int MIN_DIST_Q = 5120;
	localparam int NUDGE_Q    = 1280;
	localparam int SPAWN_DROP = 100;

	typedef enum logic [4:0] {
		S_IDLE, S_REPLY, S_SPAWN, S_NUDGE_RD, S_NUDGE_WR,
		S_ADV_RD, S_ADV_LD, S_ADV_CLAMP, S_PJ_NEXT, S_PJ_LD, S_PJ_MUL,
		S_PJ_SQ, S_PJ_SQ_WAIT, S_PJ_CHK, S_PJ_DX, S_PJ_DX_WAIT, S_PJ_DY,
		S_PJ_DY_WAIT, S_PJ_UPD, S_ADV_WB, S_EM_RD, S_EM_LD
	} state_t;

	typedef enum logic [2:0] {
		WR_NONE, WR_SPAWN, WR_NUDGE, WR_BALL_I, WR_BALL_J
	} wr_sel_t;

	typedef enum logic [1:0] {
		OSRC_ZERO, OSRC_SPAWN, OSRC_MEM
	} out_src_t;

	// commands from the controller to the datapath
	typedef struct packed {
		logic             take_in;
		logic [IDX_W-1:0] rd_addr;
		logic [IDX_W-1:0] wr_addr;
		wr_sel_t          wr_sel;
		logic             ld_adv;
		logic             clamp;
		logic             ld_pair;
		logic             ld_sq;
		logic             sqrt_start;
		logic             ld_mag;
		logic             div_start;
		logic             div_sel_y;
		logic             cap_qx;
		logic             cap_qy;
		logic             upd;
		logic             out_load;
		out_src_t         out_src;
		logic [1:0]       out_status;
		logic [IDX_W-1:0] out_index;
		logic             out_last;
	} dp_cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic out_free;
		logic sqrt_busy;
		logic sqrt_done;
		logic div_busy;
		logic div_done;
		logic overlap;
	} dp_stat_t;

	// saturate a wide sum to a signed 24-bit position
	function automatic logic signed [23:0] sat_pos(input logic signed [27:0] v);
		logic signed [23:0] r;
		if (v > 28'sd8388607)
			r = 24'sh7FFFFF;
		else if (v < -28'sd8388608)
			r = 24'sh800000;
		else
			r = v[23:0];
		return r;
	endfunction

endpackage

// ===== rtl/core/vbc_isqrt.sv =====
// ----------------------------------------------------------------------------
// vbc_isqrt
// Integer square root, one result bit per cycle, floor of the exact root.
// ----------------------------------------------------------------------------
module vbc_isqrt #(
	parameter int IN_W = 50
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [IN_W-1:0]       operand,
	output logic                  busy,
	output logic                  done,
	output logic [IN_W/2-1:0]     root
);
	localparam int OUT_W = IN_W / 2;
	localparam int CW    = $clog2(OUT_W + 1);

	logic [IN_W-1:0]  rad_q;
	logic [OUT_W:0]   rem_q;
	logic [OUT_W-1:0] root_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [OUT_W+2:0] rem_shift;
	logic [OUT_W+2:0] trial;
	logic             fits;

	// bring down two radicand bits and try the next root bit
	always_comb begin
		rem_shift = {rem_q, rad_q[IN_W-1:IN_W-2]};
		trial     = {1'b0, root_q, 2'b01};
		fits      = rem_shift >= trial;
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(OUT_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// iterate
	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= operand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q <= {rad_q[IN_W-3:0], 2'b00};
			if (fits) begin
				rem_q  <= (OUT_W+1)'(rem_shift - trial);
				root_q <= {root_q[OUT_W-2:0], 1'b1};
			end else begin
				rem_q  <= rem_shift[OUT_W:0];
				root_q <= {root_q[OUT_W-2:0], 1'b0};
			end
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign root = root_q;

endmodule

// ===== rtl/core/vbc_div.sv =====
// ----------------------------------------------------------------------------
// vbc_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module vbc_div #(
	parameter int NUM_W = 26,
	parameter int DEN_W = 14
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             busy,
	output logic             done,
	output logic [NUM_W-1:0] quo
);
	localparam int CW = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [DEN_W:0]   rem_shift;
	logic             fits;

	always_comb begin
		rem_shift = {rem_q, quo_q[NUM_W-1]};
		fits      = rem_shift >= {1'b0, den_q};
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// shift, subtract, restore
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= DEN_W'(rem_shift - {1'b0, den_q});
				quo_q <= {quo_q[NUM_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_shift[DEN_W-1:0];
				quo_q <= {quo_q[NUM_W-2:0], 1'b0};
			end
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quo  = quo_q;

endmodule

// ===== rtl/core/vbc_dp.sv =====
// ----------------------------------------------------------------------------
// vbc_dp
// Datapath: ball tables, working registers of the current ball, square root
// and divider units, configuration registers and the result register.
// ----------------------------------------------------------------------------
module vbc_dp #(
	parameter int MAX_BALLS = vbc_pkg::MAX_BALLS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	input  logic [1:0]                  cfg_index,
	input  logic [11:0]                 cfg_data,
	input  logic signed [7:0]           spawn_offset,
	input  logic signed [0:0]           spawn_drift,
	input  vbc_pkg::dp_cmd_t            dcmd,
	output vbc_pkg::dp_stat_t           stat,
	input  logic                        out_stall,
	output logic                        out_valid,
	output logic [1:0]                  status,
	output logic [vbc_pkg::IDX_W-1:0]   ball_index,
	output logic signed [23:0]          pos_x,
	output logic signed [23:0]          pos_y,
	output logic                        last
);
	localparam int IW = $clog2(MAX_BALLS);

	// configuration
	logic [11:0] aw_q;
	logic [11:0] ah_q;
	logic [7:0]  grav_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			aw_q   <= vbc_pkg::WIDTH_RST;
			ah_q   <= vbc_pkg::HEIGHT_RST;
			grav_q <= vbc_pkg::GRAVITY_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				vbc_pkg::CFG_WIDTH:   aw_q   <= cfg_data;
				vbc_pkg::CFG_HEIGHT:  ah_q   <= cfg_data;
				vbc_pkg::CFG_GRAVITY: grav_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// capture spawn fields of the accepted item
	logic signed [7:0] off_q;
	logic              drift_q;

	always_ff @(posedge clk) begin
		if (dcmd.take_in) begin
			off_q   <= spawn_offset;
			drift_q <= spawn_drift[0];
		end
	end

	// spawn position
	logic signed [13:0] sx_pix, spx_pix, sy_pix;
	logic signed [23:0] spawn_x, spawn_px, spawn_y;

	always_comb begin
		sx_pix   = $signed({3'b000, aw_q[11:1]}) + 14'(off_q);
		spx_pix  = sx_pix + {14{drift_q}};
		sy_pix   = $signed({2'b00, ah_q}) - 14'sd100;
		spawn_x  = {{2{sx_pix[13]}}, sx_pix, 8'h00};
		spawn_px = {{2{spx_pix[13]}}, spx_pix, 8'h00};
		spawn_y  = {{2{sy_pix[13]}}, sy_pix, 8'h00};
	end

	// ball tables
	logic [23:0] cx_mem [MAX_BALLS];
	logic [23:0] cy_mem [MAX_BALLS];
	logic [23:0] px_mem [MAX_BALLS];
	logic [23:0] py_mem [MAX_BALLS];

	logic signed [23:0] rcx_q, rcy_q, rpx_q, rpy_q;
	logic signed [23:0] wcx, wcy, wpx, wpy;
	logic               we_cur, we_px, we_py;

	// working registers
	logic signed [23:0] xi_q, yi_q, pxi_q, pyi_q;
	logic        [24:0] avx_q;
	logic        [25:0] avy_q;
	logic signed [23:0] xj_q, yj_q;
	logic signed [24:0] dx_q, dy_q;
	logic        [49:0] sqx_q, sqy_q;
	logic        [25:0] magx_q, magy_q;
	logic        [13:0] den_q;
	logic               sx_q, sy_q;
	logic        [12:0] qx_q, qy_q;

	logic signed [13:0] mx, my;
	logic signed [23:0] xj_new, yj_new;

	// write data per writer
	always_comb begin
		wcx    = xi_q;
		wcy    = yi_q;
		wpx    = pxi_q;
		wpy    = pyi_q;
		we_cur = 1'b0;
		we_px  = 1'b0;
		we_py  = 1'b0;
		unique case (dcmd.wr_sel)
			vbc_pkg::WR_SPAWN: begin
				wcx    = spawn_x;
				wcy    = spawn_y;
				wpx    = spawn_px;
				wpy    = spawn_y;
				we_cur = 1'b1;
				we_px  = 1'b1;
				we_py  = 1'b1;
			end
			vbc_pkg::WR_NUDGE: begin
				wpx   = vbc_pkg::sat_pos(28'(rcx_q) - 28'sd1280);
				we_px = 1'b1;
			end
			vbc_pkg::WR_BALL_I: begin
				we_cur = 1'b1;
				we_px  = 1'b1;
				we_py  = 1'b1;
			end
			vbc_pkg::WR_BALL_J: begin
				wcx    = xj_new;
				wcy    = yj_new;
				we_cur = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we_cur) begin
			cx_mem[dcmd.wr_addr[IW-1:0]] <= wcx;
			cy_mem[dcmd.wr_addr[IW-1:0]] <= wcy;
		end
		if (we_px)
			px_mem[dcmd.wr_addr[IW-1:0]] <= wpx;
		if (we_py)
			py_mem[dcmd.wr_addr[IW-1:0]] <= wpy;
		rcx_q <= cx_mem[dcmd.rd_addr[IW-1:0]];
		rcy_q <= cy_mem[dcmd.rd_addr[IW-1:0]];
		rpx_q <= px_mem[dcmd.rd_addr[IW-1:0]];
		rpy_q <= py_mem[dcmd.rd_addr[IW-1:0]];
	end

	// advance: velocity from the last step, gravity on y
	logic signed [24:0] vx;
	logic signed [25:0] vy;

	always_comb begin
		vx = 25'(rcx_q) - 25'(rpx_q);
		vy = 26'(rcy_q) - 26'(rpy_q) - $signed({18'b0, grav_q});
	end

	// wall and floor clamp
	logic signed [27:0] right;
	logic signed [23:0] cl_x, cl_px, cl_y, cl_py;

	always_comb begin
		right = $signed({8'b0, aw_q, 8'b0}) - 28'sd2560;
		cl_x  = xi_q;
		cl_px = pxi_q;
		cl_y  = yi_q;
		cl_py = pyi_q;
		if (28'(xi_q) > right) begin
			cl_x  = right[23:0];
			cl_px = vbc_pkg::sat_pos(right + $signed({3'b000, avx_q}));
		end
		if (cl_x < 24'sd2560) begin
			cl_x  = 24'sd2560;
			cl_px = vbc_pkg::sat_pos(28'sd2560 - $signed({3'b000, avx_q}));
		end
		if (yi_q < 24'sd2560) begin
			cl_y  = 24'sd2560;
			cl_py = vbc_pkg::sat_pos(28'sd2560 - $signed({2'b00, avy_q}));
		end
	end

	// pair squares
	logic signed [49:0] sqx_w, sqy_w;
	assign sqx_w = dx_q * dx_q;
	assign sqy_w = dy_q * dy_q;

	// square root unit
	logic        sq_busy, sq_done;
	logic [24:0] sep;

	vbc_isqrt #(
		.IN_W (50)
	) u_isqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (dcmd.sqrt_start),
		.operand (sqx_q + sqy_q),
		.busy    (sq_busy),
		.done    (sq_done),
		.root    (sep)
	);

	// overlap magnitudes: both |dx| and |dy| are at most the separation when overlapping
	logic        [24:0] adx, ady;
	logic        [12:0] negd;

	always_comb begin
		adx  = dx_q[24] ? 25'(-dx_q) : 25'(dx_q);
		ady  = dy_q[24] ? 25'(-dy_q) : 25'(dy_q);
		negd = 13'(13'd5120 - sep[12:0]);
	end

	// divider unit
	logic        dv_busy, dv_done;
	logic [25:0] quo;

	vbc_div #(
		.NUM_W (26),
		.DEN_W (14)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (dcmd.div_start),
		.num    (dcmd.div_sel_y ? magy_q : magx_q),
		.den    (den_q),
		.busy   (dv_busy),
		.done   (dv_done),
		.quo    (quo)
	);

	// push: the pair moves apart, ball j against the sign of the offset and ball i along it
	always_comb begin
		mx     = sx_q ? $signed({1'b0, qx_q}) : -$signed({1'b0, qx_q});
		my     = sy_q ? $signed({1'b0, qy_q}) : -$signed({1'b0, qy_q});
		xj_new = vbc_pkg::sat_pos(28'(xj_q) + 28'(mx));
		yj_new = vbc_pkg::sat_pos(28'(yj_q) + 28'(my));
	end

	// working register updates
	always_ff @(posedge clk) begin
		if (dcmd.ld_adv) begin
			pxi_q <= rcx_q;
			pyi_q <= rcy_q;
			xi_q  <= vbc_pkg::sat_pos(28'(rcx_q) + 28'(vx));
			yi_q  <= vbc_pkg::sat_pos(28'(rcy_q) + 28'(vy));
			avx_q <= vx[24] ? 25'(-vx) : 25'(vx);
			avy_q <= vy[25] ? 26'(-vy) : 26'(vy);
		end else if (dcmd.clamp) begin
			xi_q  <= cl_x;
			pxi_q <= cl_px;
			yi_q  <= cl_y;
			pyi_q <= cl_py;
		end else if (dcmd.upd) begin
			xi_q <= vbc_pkg::sat_pos(28'(xi_q) - 28'(mx));
			yi_q <= vbc_pkg::sat_pos(28'(yi_q) - 28'(my));
		end
		if (dcmd.ld_pair) begin
			xj_q <= rcx_q;
			yj_q <= rcy_q;
			dx_q <= 25'(xi_q) - 25'(rcx_q);
			dy_q <= 25'(yi_q) - 25'(rcy_q);
		end
		if (dcmd.ld_sq) begin
			sqx_q <= $unsigned(sqx_w);
			sqy_q <= $unsigned(sqy_w);
		end
		if (dcmd.ld_mag) begin
			magx_q <= adx[12:0] * negd;
			magy_q <= ady[12:0] * negd;
			den_q  <= {sep[12:0], 1'b0};
			sx_q   <= dx_q[24];
			sy_q   <= dy_q[24];
		end
		if (dcmd.cap_qx)
			qx_q <= quo[12:0];
		if (dcmd.cap_qy)
			qy_q <= quo[12:0];
	end

	// result register
	logic out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (dcmd.out_load)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (dcmd.out_load) begin
			status     <= dcmd.out_status;
			ball_index <= dcmd.out_index;
			last       <= dcmd.out_last;
			unique case (dcmd.out_src)
				vbc_pkg::OSRC_SPAWN: begin
					pos_x <= spawn_x;
					pos_y <= spawn_y;
				end
				vbc_pkg::OSRC_MEM: begin
					pos_x <= rcx_q;
					pos_y <= rcy_q;
				end
				default: begin
					pos_x <= '0;
					pos_y <= '0;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;

	// status
	always_comb begin
		stat.out_free  = !out_valid_q || !out_stall;
		stat.sqrt_busy = sq_busy;
		stat.sqrt_done = sq_done;
		stat.div_busy  = dv_busy;
		stat.div_done  = dv_done;
		stat.overlap   = (sep != '0) && (sep < 25'd5120);
	end

endmodule

// ===== rtl/core/vbc_ctrl.sv =====
// ----------------------------------------------------------------------------
// vbc_ctrl
// Controller: decodes items, walks balls and pairs, sequences the datapath.
// ----------------------------------------------------------------------------
module vbc_ctrl #(
	parameter int MAX_BALLS = vbc_pkg::MAX_BALLS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic [1:0]         cmd,
	output logic               in_stall,
	output vbc_pkg::dp_cmd_t   dcmd,
	input  vbc_pkg::dp_stat_t  stat
);
	localparam int IW   = $clog2(MAX_BALLS);
	localparam int CW   = $clog2(MAX_BALLS + 1);
	localparam int IDXW = vbc_pkg::IDX_W;

	vbc_pkg::state_t state_q, state_d;
	logic [CW-1:0]   cnt_q, cnt_d;
	logic [CW-1:0]   i_q, i_d;
	logic [CW-1:0]   j_q, j_d;
	logic [1:0]      rsp_q, rsp_d;
	logic [IDXW-1:0] i_idx, j_idx, cnt_idx;
	logic            i_last;

	assign i_idx   = IDXW'(i_q[IW-1:0]);
	assign j_idx   = IDXW'(j_q[IW-1:0]);
	assign cnt_idx = IDXW'(cnt_q[IW-1:0]);
	assign i_last  = (i_q + CW'(1)) == cnt_q;

	// state and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= vbc_pkg::S_IDLE;
			cnt_q   <= '0;
			i_q     <= '0;
			j_q     <= '0;
			rsp_q   <= vbc_pkg::STAT_OK;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			i_q     <= i_d;
			j_q     <= j_d;
			rsp_q   <= rsp_d;
		end
	end

	// next state and datapath commands
	always_comb begin
		state_d         = state_q;
		cnt_d           = cnt_q;
		i_d             = i_q;
		j_d             = j_q;
		rsp_d           = rsp_q;
		in_stall        = 1'b1;
		dcmd            = '0;
		dcmd.wr_sel     = vbc_pkg::WR_NONE;
		dcmd.out_src    = vbc_pkg::OSRC_ZERO;
		dcmd.out_status = vbc_pkg::STAT_OK;
		unique case (state_q)
			vbc_pkg::S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					dcmd.take_in = 1'b1;
					unique case (cmd)
						vbc_pkg::CMD_TICK: begin
							if (cnt_q == '0) begin
								rsp_d   = vbc_pkg::STAT_OK;
								state_d = vbc_pkg::S_REPLY;
							end else begin
								i_d     = '0;
								state_d = vbc_pkg::S_ADV_RD;
							end
						end
						vbc_pkg::CMD_SPAWN: begin
							if (cnt_q == CW'(MAX_BALLS)) begin
								rsp_d   = vbc_pkg::STAT_FULL;
								state_d = vbc_pkg::S_REPLY;
							end else begin
								state_d = vbc_pkg::S_SPAWN;
							end
						end
						vbc_pkg::CMD_NUDGE: begin
							if (cnt_q == '0) begin
								rsp_d   = vbc_pkg::STAT_NO_BALL;
								state_d = vbc_pkg::S_REPLY;
							end else begin
								state_d = vbc_pkg::S_NUDGE_RD;
							end
						end
						default: ;
					endcase
				end
			end
			vbc_pkg::S_REPLY: begin
				dcmd.out_status = rsp_q;
				dcmd.out_last   = 1'b1;
				if (stat.out_free) begin
					dcmd.out_load = 1'b1;
					state_d       = vbc_pkg::S_IDLE;
				end
			end
			vbc_pkg::S_SPAWN: begin
				dcmd.wr_addr   = cnt_idx;
				dcmd.out_src   = vbc_pkg::OSRC_SPAWN;
				dcmd.out_index = cnt_idx;
				dcmd.out_last  = 1'b1;
				if (stat.out_free) begin
					dcmd.wr_sel   = vbc_pkg::WR_SPAWN;
					dcmd.out_load = 1'b1;
					cnt_d         = cnt_q + CW'(1);
					state_d       = vbc_pkg::S_IDLE;
				end
			end
			vbc_pkg::S_NUDGE_RD: begin
				state_d = vbc_pkg::S_NUDGE_WR;
			end
			vbc_pkg::S_NUDGE_WR: begin
				dcmd.out_src  = vbc_pkg::OSRC_MEM;
				dcmd.out_last = 1'b1;
				if (stat.out_free) begin
					dcmd.wr_sel   = vbc_pkg::WR_NUDGE;
					dcmd.out_load = 1'b1;
					state_d       = vbc_pkg::S_IDLE;
				end
			end
			vbc_pkg::S_ADV_RD: begin
				dcmd.rd_addr = i_idx;
				state_d      = vbc_pkg::S_ADV_LD;
			end
			vbc_pkg::S_ADV_LD: begin
				dcmd.ld_adv = 1'b1;
				state_d     = vbc_pkg::S_ADV_CLAMP;
			end
			vbc_pkg::S_ADV_CLAMP: begin
				dcmd.clamp = 1'b1;
				j_d        = '0;
				state_d    = vbc_pkg::S_PJ_NEXT;
			end
			vbc_pkg::S_PJ_NEXT: begin
				dcmd.rd_addr = j_idx;
				if (j_q == cnt_q)
					state_d = vbc_pkg::S_ADV_WB;
				else if (j_q == i_q)
					j_d = j_q + CW'(1);
				else
					state_d = vbc_pkg::S_PJ_LD;
			end
			vbc_pkg::S_PJ_LD: begin
				dcmd.ld_pair = 1'b1;
				state_d      = vbc_pkg::S_PJ_MUL;
			end
			vbc_pkg::S_PJ_MUL: begin
				dcmd.ld_sq = 1'b1;
				state_d    = vbc_pkg::S_PJ_SQ;
			end
			vbc_pkg::S_PJ_SQ: begin
				dcmd.sqrt_start = 1'b1;
				state_d         = vbc_pkg::S_PJ_SQ_WAIT;
			end
			vbc_pkg::S_PJ_SQ_WAIT: begin
				if (stat.sqrt_done)
					state_d = vbc_pkg::S_PJ_CHK;
			end
			vbc_pkg::S_PJ_CHK: begin
				if (stat.overlap) begin
					dcmd.ld_mag = 1'b1;
					state_d     = vbc_pkg::S_PJ_DX;
				end else begin
					j_d     = j_q + CW'(1);
					state_d = vbc_pkg::S_PJ_NEXT;
				end
			end
			vbc_pkg::S_PJ_DX: begin
				dcmd.div_start = 1'b1;
				state_d        = vbc_pkg::S_PJ_DX_WAIT;
			end
			vbc_pkg::S_PJ_DX_WAIT: begin
				if (stat.div_done) begin
					dcmd.cap_qx = 1'b1;
					state_d     = vbc_pkg::S_PJ_DY;
				end
			end
			vbc_pkg::S_PJ_DY: begin
				dcmd.div_start = 1'b1;
				dcmd.div_sel_y = 1'b1;
				state_d        = vbc_pkg::S_PJ_DY_WAIT;
			end
			vbc_pkg::S_PJ_DY_WAIT: begin
				if (stat.div_done) begin
					dcmd.cap_qy = 1'b1;
					state_d     = vbc_pkg::S_PJ_UPD;
				end
			end
			vbc_pkg::S_PJ_UPD: begin
				dcmd.upd     = 1'b1;
				dcmd.wr_sel  = vbc_pkg::WR_BALL_J;
				dcmd.wr_addr = j_idx;
				j_d          = j_q + CW'(1);
				state_d      = vbc_pkg::S_PJ_NEXT;
			end
			vbc_pkg::S_ADV_WB: begin
				dcmd.wr_sel  = vbc_pkg::WR_BALL_I;
				dcmd.wr_addr = i_idx;
				if (i_last) begin
					i_d     = '0;
					state_d = vbc_pkg::S_EM_RD;
				end else begin
					i_d     = i_q + CW'(1);
					state_d = vbc_pkg::S_ADV_RD;
				end
			end
			vbc_pkg::S_EM_RD: begin
				dcmd.rd_addr = i_idx;
				state_d      = vbc_pkg::S_EM_LD;
			end
			vbc_pkg::S_EM_LD: begin
				dcmd.rd_addr   = i_idx;
				dcmd.out_src   = vbc_pkg::OSRC_MEM;
				dcmd.out_index = i_idx;
				dcmd.out_last  = i_last;
				if (stat.out_free) begin
					dcmd.out_load = 1'b1;
					if (i_last) begin
						state_d = vbc_pkg::S_IDLE;
					end else begin
						i_d     = i_q + CW'(1);
						state_d = vbc_pkg::S_EM_RD;
					end
				end
			end
			default: state_d = vbc_pkg::S_IDLE;
		endcase
	end

endmodule

// ===== rtl/core/verlet_ball_collision_step_top.sv =====
// ----------------------------------------------------------------------------
// verlet_ball_collision_step_top
// Verlet ball simulation with circle collisions in signed Q16.8.
//
// Input channel (in_valid/in_stall) takes one command: tick, spawn or nudge.
// Output channel (out_valid/out_stall) returns result items; a tick returns
// one per ball with last on the final, or one if none; others return one.
// Configuration (cfg_valid/cfg_ready, cfg_index, cfg_data) writes arena
// width, arena height and gravity; cfg_ready is always high, and writes are
// meant for idle periods only.
// One item is worked on at a time; in_stall is low only when idle.
// During a tick every pair waits on the serial square root, and an
// overlapping pair also waits on the serial divider twice.
// A result waits in the output register while out_stall is high; the next
// result load waits for it, and the next item may be taken meanwhile.
// Reset clears the ball count and the result valid flag and restores the
// configuration defaults; the ball tables need no clearing.
// ----------------------------------------------------------------------------
module verlet_ball_collision_step_top #(
	parameter int MAX_BALLS = vbc_pkg::MAX_BALLS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [1:0]                cmd,
	input  logic signed [7:0]         spawn_offset,
	input  logic signed [0:0]         spawn_drift,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [1:0]                status,
	output logic [vbc_pkg::IDX_W-1:0] ball_index,
	output logic signed [23:0]        pos_x,
	output logic signed [23:0]        pos_y,
	output logic                      last,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [1:0]                cfg_index,
	input  logic [11:0]               cfg_data
);
	vbc_pkg::dp_cmd_t  dcmd;
	vbc_pkg::dp_stat_t stat;

	assign cfg_ready = 1'b1;

	vbc_ctrl #(
		.MAX_BALLS (MAX_BALLS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.cmd      (cmd),
		.in_stall (in_stall),
		.dcmd     (dcmd),
		.stat     (stat)
	);

	vbc_dp #(
		.MAX_BALLS (MAX_BALLS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.spawn_offset (spawn_offset),
		.spawn_drift  (spawn_drift),
		.dcmd         (dcmd),
		.stat         (stat),
		.out_stall    (out_stall),
		.out_valid    (out_valid),
		.status       (status),
		.ball_index   (ball_index),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.last         (last)
	);

	// never restart a unit that is still iterating
	a_sqrt_start: assert property (@(posedge clk) disable iff (!arst_n)
		dcmd.sqrt_start |-> !stat.sqrt_busy)
		else $error("square root restarted while busy");

	a_div_start: assert property (@(posedge clk) disable iff (!arst_n)
		dcmd.div_start |-> !stat.div_busy)
		else $error("divider restarted while busy");

	// a new result never overwrites one still held by the receiver
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		dcmd.out_load |-> (!out_valid || !out_stall))
		else $error("result overwritten while stalled");

	// tables change only while an item is in progress
	a_wr_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(dcmd.wr_sel != vbc_pkg::WR_NONE) |-> in_stall)
		else $error("table written while idle");

endmodule
